// File: design/dlts_pkg.sv
`default_nettype none
package dlts_pkg;

	localparam int MAX_SLOTS_DEF = 16;
	localparam int MAX_OUT       = 16;

	localparam logic [1:0] CMD_TICK     = 2'd0;
	localparam logic [1:0] CMD_ADD      = 2'd1;
	localparam logic [1:0] CMD_DELETE   = 2'd2;
	localparam logic [1:0] CMD_DISPATCH = 2'd3;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_FAIL = 2'd1;
	localparam logic [1:0] ST_NONE = 2'd2;

	// datapath micro-operations, one per cycle
	localparam int OP_W = 5;
	localparam logic [OP_W-1:0] OP_NONE       = 5'd0;
	localparam logic [OP_W-1:0] OP_LOAD       = 5'd1;
	localparam logic [OP_W-1:0] OP_RD_HEAD    = 5'd2;
	localparam logic [OP_W-1:0] OP_RD_CUR     = 5'd3;
	localparam logic [OP_W-1:0] OP_RD_NXT     = 5'd4;
	localparam logic [OP_W-1:0] OP_TICK_WR    = 5'd5;
	localparam logic [OP_W-1:0] OP_ADD_INIT   = 5'd6;
	localparam logic [OP_W-1:0] OP_WALK_NEXT  = 5'd7;
	localparam logic [OP_W-1:0] OP_ADD_APPEND = 5'd8;
	localparam logic [OP_W-1:0] OP_ADD_SPLIT  = 5'd9;
	localparam logic [OP_W-1:0] OP_ADD_LINK_S = 5'd10;
	localparam logic [OP_W-1:0] OP_ADD_LINK_P = 5'd11;
	localparam logic [OP_W-1:0] OP_DEL_INIT   = 5'd12;
	localparam logic [OP_W-1:0] OP_DEL_HIT    = 5'd13;
	localparam logic [OP_W-1:0] OP_DEL_FIX    = 5'd14;
	localparam logic [OP_W-1:0] OP_DEL_UNLINK = 5'd15;
	localparam logic [OP_W-1:0] OP_DSP_INIT   = 5'd16;
	localparam logic [OP_W-1:0] OP_DSP_TAKE   = 5'd17;
	localparam logic [OP_W-1:0] OP_EMIT_OK    = 5'd18;
	localparam logic [OP_W-1:0] OP_EMIT_FAIL  = 5'd19;
	localparam logic [OP_W-1:0] OP_EMIT_ADD   = 5'd20;
	localparam logic [OP_W-1:0] OP_EMIT_DEL   = 5'd21;
	localparam logic [OP_W-1:0] OP_EMIT_NONE  = 5'd22;
	localparam logic [OP_W-1:0] OP_EMIT_LAST  = 5'd23;

	typedef struct packed {
		logic [1:0]  command;
		logic [7:0]  task_tag;
		logic [31:0] start_delay;
		logic [31:0] repeat_period;
		logic [31:0] target_id;
	} in_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] result_id;
		logic [7:0]  result_tag;
		logic        is_last;
	} out_t;

	typedef struct packed {
		logic head_valid;
		logic cur_valid;
		logic nxt_valid;
		logic walk_gt;
		logic id_match;
		logic add_bad;
		logic target_zero;
		logic n_ok;
		logic due;
		logic per_nz;
		logic pend;
	} dp_stat_t;

endpackage
`default_nettype wire

// File: design/dlts_ctrl.sv
`default_nettype none
module dlts_ctrl
	import dlts_pkg::*;
(
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            start,
	input  wire logic [1:0]      command,
	input  wire dp_stat_t        stat,
	output logic                 busy,
	output logic [OP_W-1:0]      op
);

	localparam logic [4:0] S_IDLE = 5'd0;
	localparam logic [4:0] S_DEC  = 5'd1;
	localparam logic [4:0] S_T1   = 5'd2;
	localparam logic [4:0] S_T2   = 5'd3;
	localparam logic [4:0] S_A1   = 5'd4;
	localparam logic [4:0] S_A2   = 5'd5;
	localparam logic [4:0] S_A3   = 5'd6;
	localparam logic [4:0] S_A4   = 5'd7;
	localparam logic [4:0] S_AE   = 5'd8;
	localparam logic [4:0] S_D1   = 5'd9;
	localparam logic [4:0] S_D2   = 5'd10;
	localparam logic [4:0] S_D3   = 5'd11;
	localparam logic [4:0] S_D4   = 5'd12;
	localparam logic [4:0] S_D5   = 5'd13;
	localparam logic [4:0] S_DE   = 5'd14;
	localparam logic [4:0] S_P1   = 5'd15;
	localparam logic [4:0] S_P2   = 5'd16;
	localparam logic [4:0] S_P3   = 5'd17;
	localparam logic [4:0] S_PE   = 5'd18;

	logic [4:0] state_q, state_d;
	logic [1:0] cmd_q;

	assign busy = (state_q != S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cmd_q   <= CMD_TICK;
		end else begin
			state_q <= state_d;
			if (state_q == S_IDLE && start) cmd_q <= command;
		end
	end

	always_comb begin
		state_d = state_q;
		op      = OP_NONE;
		case (state_q)
			S_IDLE: if (start) begin
				op      = OP_LOAD;
				state_d = S_DEC;
			end
			S_DEC: begin
				case (cmd_q)
					CMD_TICK: begin
						if (stat.head_valid) begin
							op = OP_RD_HEAD; state_d = S_T1;
						end else begin
							op = OP_EMIT_OK; state_d = S_IDLE;
						end
					end
					CMD_ADD: begin
						if (stat.add_bad) begin
							op = OP_EMIT_FAIL; state_d = S_IDLE;
						end else begin
							op = OP_ADD_INIT; state_d = S_A1;
						end
					end
					CMD_DELETE: begin
						if (stat.target_zero) begin
							op = OP_EMIT_FAIL; state_d = S_IDLE;
						end else begin
							op = OP_DEL_INIT; state_d = S_D1;
						end
					end
					default: begin
						op = OP_DSP_INIT; state_d = S_P1;
					end
				endcase
			end
			S_T1: begin
				op = OP_TICK_WR; state_d = S_T2;
			end
			S_T2: begin
				op = OP_EMIT_OK; state_d = S_IDLE;
			end
			S_A1: begin
				if (stat.cur_valid) begin
					op = OP_RD_CUR; state_d = S_A2;
				end else begin
					op = OP_ADD_APPEND; state_d = S_A3;
				end
			end
			S_A2: begin
				if (stat.walk_gt) begin
					op = OP_ADD_SPLIT; state_d = S_A3;
				end else begin
					op = OP_WALK_NEXT; state_d = S_A1;
				end
			end
			S_A3: begin
				op = OP_ADD_LINK_S; state_d = S_A4;
			end
			S_A4: begin
				op      = OP_ADD_LINK_P;
				state_d = (cmd_q == CMD_ADD) ? S_AE : S_P1;
			end
			S_AE: begin
				op = OP_EMIT_ADD; state_d = S_IDLE;
			end
			S_D1: begin
				if (stat.cur_valid) begin
					op = OP_RD_CUR; state_d = S_D2;
				end else begin
					op = OP_EMIT_FAIL; state_d = S_IDLE;
				end
			end
			S_D2: begin
				if (stat.id_match) begin
					op = OP_DEL_HIT; state_d = S_D3;
				end else begin
					op = OP_WALK_NEXT; state_d = S_D1;
				end
			end
			S_D3: begin
				if (stat.nxt_valid) begin
					op = OP_RD_NXT; state_d = S_D4;
				end else begin
					state_d = S_D5;
				end
			end
			S_D4: begin
				op = OP_DEL_FIX; state_d = S_D5;
			end
			S_D5: begin
				op = OP_DEL_UNLINK; state_d = S_DE;
			end
			S_DE: begin
				op = OP_EMIT_DEL; state_d = S_IDLE;
			end
			S_P1: begin
				if (stat.n_ok && stat.head_valid) begin
					op = OP_RD_HEAD; state_d = S_P2;
				end else begin
					state_d = S_PE;
				end
			end
			S_P2: begin
				if (stat.due) begin
					op = OP_DSP_TAKE; state_d = S_P3;
				end else begin
					state_d = S_PE;
				end
			end
			S_P3: begin
				if (stat.per_nz) begin
					op = OP_ADD_INIT; state_d = S_A1;
				end else begin
					state_d = S_P1;
				end
			end
			S_PE: begin
				op      = stat.pend ? OP_EMIT_LAST : OP_EMIT_NONE;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule
`default_nettype wire

// File: design/dlts_datapath.sv
`default_nettype none
module dlts_datapath
	import dlts_pkg::*;
#(
	parameter int MAX_SLOTS = MAX_SLOTS_DEF
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic [OP_W-1:0] op,
	input  wire in_t             request,
	output dp_stat_t             stat,
	output out_t                 result,
	output logic                 result_valid
);

	localparam int IW = $clog2(MAX_SLOTS + 1);
	localparam int AW = $clog2(MAX_SLOTS);
	localparam int NW = $clog2(MAX_OUT + 1);
	localparam logic [IW-1:0] NIL = IW'(MAX_SLOTS);

	logic [31:0]   delay_mem [MAX_SLOTS];
	logic [31:0]   per_mem   [MAX_SLOTS];
	logic [7:0]    tag_mem   [MAX_SLOTS];
	logic [31:0]   id_mem    [MAX_SLOTS];
	logic [IW-1:0] link_mem  [MAX_SLOTS];

	logic [MAX_SLOTS-1:0] used_q;
	logic [IW-1:0] head_q, total_q, s_q, prev_q, cur_q, nxt_q, succ_q;
	logic [31:0]   idc_q, dly_q, per_q, target_q, fix_q, cdel_q, pid_q;
	logic [7:0]    tag_q, ptag_q;
	logic [32:0]   acc_q;
	logic          fix_en_q, pend_q;
	logic [NW-1:0] n_q;

	logic [31:0]   rd_delay, rd_per, rd_id;
	logic [7:0]    rd_tag;
	logic [IW-1:0] rd_link;

	logic [IW-1:0] free_idx;
	logic [32:0]   sum;
	logic          re;
	logic [AW-1:0] raddr;
	logic          dly_we, link_we, ent_we;
	logic [AW-1:0] dly_wa, link_wa;
	logic [31:0]   dly_wd;
	logic [IW-1:0] link_wd;

	// lowest free slot
	always_comb begin
		free_idx = NIL;
		for (int i = MAX_SLOTS - 1; i >= 0; i--) begin
			if (!used_q[i]) free_idx = IW'(i);
		end
	end

	assign sum = acc_q + {1'b0, rd_delay};

	assign stat.head_valid  = head_q < NIL;
	assign stat.cur_valid   = cur_q < NIL;
	assign stat.nxt_valid   = nxt_q < NIL;
	assign stat.walk_gt     = sum > {1'b0, dly_q};
	assign stat.id_match    = rd_id == target_q;
	assign stat.add_bad     = (tag_q == 8'd0) || (total_q == NIL);
	assign stat.target_zero = target_q == 32'd0;
	assign stat.n_ok        = n_q < NW'(MAX_OUT);
	assign stat.due         = (rd_delay == 32'd0) && (rd_id != 32'd0);
	assign stat.per_nz      = per_q != 32'd0;
	assign stat.pend        = pend_q;

	always_comb begin
		re    = 1'b0;
		raddr = cur_q[AW-1:0];
		case (op)
			OP_RD_HEAD: begin re = 1'b1; raddr = head_q[AW-1:0]; end
			OP_RD_CUR:  begin re = 1'b1; raddr = cur_q[AW-1:0]; end
			OP_RD_NXT:  begin re = 1'b1; raddr = nxt_q[AW-1:0]; end
			default:    re = 1'b0;
		endcase
	end

	always_comb begin
		dly_we  = 1'b0;
		dly_wa  = s_q[AW-1:0];
		dly_wd  = dly_q - acc_q[31:0];
		link_we = 1'b0;
		link_wa = s_q[AW-1:0];
		link_wd = succ_q;
		ent_we  = 1'b0;
		case (op)
			OP_ADD_INIT: ent_we = 1'b1;
			OP_ADD_LINK_S: begin
				dly_we  = 1'b1;
				link_we = 1'b1;
			end
			OP_ADD_LINK_P: begin
				dly_we  = fix_en_q;
				dly_wa  = cur_q[AW-1:0];
				dly_wd  = fix_q;
				link_we = prev_q < NIL;
				link_wa = prev_q[AW-1:0];
				link_wd = s_q;
			end
			OP_TICK_WR: begin
				dly_we = rd_delay != 32'd0;
				dly_wa = head_q[AW-1:0];
				dly_wd = rd_delay - 32'd1;
			end
			OP_DEL_FIX: begin
				dly_we = 1'b1;
				dly_wa = nxt_q[AW-1:0];
				dly_wd = rd_delay + cdel_q;
			end
			OP_DEL_UNLINK: begin
				link_we = prev_q < NIL;
				link_wa = prev_q[AW-1:0];
				link_wd = nxt_q;
			end
			default: dly_we = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (dly_we) delay_mem[dly_wa] <= dly_wd;
		if (link_we) link_mem[link_wa] <= link_wd;
		if (ent_we) begin
			tag_mem[free_idx[AW-1:0]] <= tag_q;
			per_mem[free_idx[AW-1:0]] <= per_q;
			id_mem[free_idx[AW-1:0]]  <= idc_q + 32'd1;
		end
		if (re) begin
			rd_delay <= delay_mem[raddr];
			rd_per   <= per_mem[raddr];
			rd_tag   <= tag_mem[raddr];
			rd_id    <= id_mem[raddr];
			rd_link  <= link_mem[raddr];
		end
	end

	// working registers of the current command
	always_ff @(posedge clk) begin
		case (op)
			OP_LOAD: begin
				tag_q    <= request.task_tag;
				dly_q    <= request.start_delay;
				per_q    <= request.repeat_period;
				target_q <= request.target_id;
			end
			OP_ADD_INIT: begin
				s_q    <= free_idx;
				prev_q <= NIL;
				cur_q  <= head_q;
				acc_q  <= 33'd0;
			end
			OP_WALK_NEXT: begin
				acc_q  <= sum;
				prev_q <= cur_q;
				cur_q  <= rd_link;
			end
			OP_ADD_APPEND: begin
				succ_q   <= NIL;
				fix_en_q <= 1'b0;
			end
			OP_ADD_SPLIT: begin
				succ_q   <= cur_q;
				fix_en_q <= 1'b1;
				fix_q    <= sum[31:0] - dly_q;
			end
			OP_DEL_INIT: begin
				prev_q <= NIL;
				cur_q  <= head_q;
			end
			OP_DEL_HIT: begin
				nxt_q  <= rd_link;
				cdel_q <= rd_delay;
			end
			OP_DSP_TAKE: begin
				pid_q  <= rd_id;
				ptag_q <= rd_tag;
				tag_q  <= rd_tag;
				dly_q  <= rd_per;
				per_q  <= rd_per;
			end
			default: acc_q <= acc_q;
		endcase
	end

	// list control state and result beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q       <= '0;
			head_q       <= NIL;
			total_q      <= '0;
			idc_q        <= 32'd0;
			n_q          <= '0;
			pend_q       <= 1'b0;
			result_valid <= 1'b0;
			result       <= '0;
		end else begin
			result_valid <= 1'b0;
			case (op)
				OP_ADD_INIT: begin
					used_q[free_idx[AW-1:0]] <= 1'b1;
					total_q <= total_q + IW'(1);
					idc_q   <= idc_q + 32'd1;
				end
				OP_ADD_LINK_P: if (!(prev_q < NIL)) head_q <= s_q;
				OP_DEL_UNLINK: begin
					if (!(prev_q < NIL)) head_q <= nxt_q;
					used_q[cur_q[AW-1:0]] <= 1'b0;
					total_q <= total_q - IW'(1);
				end
				OP_DSP_INIT: begin
					n_q    <= '0;
					pend_q <= 1'b0;
				end
				OP_DSP_TAKE: begin
					head_q <= rd_link;
					used_q[head_q[AW-1:0]] <= 1'b0;
					total_q <= total_q - IW'(1);
					n_q     <= n_q + NW'(1);
					pend_q  <= 1'b1;
					if (pend_q) begin
						result_valid <= 1'b1;
						result       <= '{ST_OK, pid_q, ptag_q, 1'b0};
					end
				end
				OP_EMIT_OK: begin
					result_valid <= 1'b1;
					result       <= '{ST_OK, 32'd0, 8'd0, 1'b1};
				end
				OP_EMIT_FAIL: begin
					result_valid <= 1'b1;
					result       <= '{ST_FAIL, 32'd0, 8'd0, 1'b1};
				end
				OP_EMIT_ADD: begin
					result_valid <= 1'b1;
					result       <= '{ST_OK, idc_q, 8'd0, 1'b1};
				end
				OP_EMIT_DEL: begin
					result_valid <= 1'b1;
					result       <= '{ST_OK, target_q, 8'd0, 1'b1};
				end
				OP_EMIT_NONE: begin
					result_valid <= 1'b1;
					result       <= '{ST_NONE, 32'd0, 8'd0, 1'b1};
				end
				OP_EMIT_LAST: begin
					result_valid <= 1'b1;
					result       <= '{ST_OK, pid_q, ptag_q, 1'b1};
				end
				default: pend_q <= pend_q;
			endcase
		end
	end

endmodule
`default_nettype wire

// File: design/delta_list_task_scheduler_unit.sv
// Channel   Signals                  Beat taken when
// --------  -----------------------  ----------------------------------
// command   start, busy, request     rising edge with start=1, busy=0
// result    result_valid, result     every edge with result_valid=1
//
// A tick or a rejected add does not walk the list; an add or a delete may
// walk the whole list, and each list entry visited costs one registered
// read of the slot memories plus one compare/advance step. A dispatch
// repeats head removal and a requeue walk per due task, at most 16 tasks.
// Reset clears the list head, occupancy bits, task count and id counter at
// once; slot memories need no clearing. Results are driven for one cycle
// each and cannot be stalled by the receiver.
`default_nettype none
module delta_list_task_scheduler_unit
	import dlts_pkg::*;
#(
	parameter int MAX_SLOTS = MAX_SLOTS_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	output logic      busy,
	input  wire in_t  request,
	output logic      result_valid,
	output out_t      result
);

	logic [OP_W-1:0] op;
	dp_stat_t        stat;

	// sequence list walks and result beats
	dlts_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.command (request.command),
		.stat    (stat),
		.busy    (busy),
		.op      (op)
	);

	// hold slot memories, list pointers and the result register
	dlts_datapath #(
		.MAX_SLOTS (MAX_SLOTS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.op           (op),
		.request      (request),
		.stat         (stat),
		.result       (result),
		.result_valid (result_valid)
	);

endmodule
`default_nettype wire

// File: dv/testbench.sv
`timescale 1ns / 100ps
`default_nettype none

// Timer queue scoreboard: holds its own copy of the delta list and predicts
// every result beat caused by an accepted command.
class timer_queue_board;
	localparam int SLOTS = dlts_pkg::MAX_SLOTS_DEF;
	localparam int NIL = SLOTS;

	bit [31:0] delay_of[SLOTS];
	bit [31:0] period_of[SLOTS];
	bit [7:0]  tag_of[SLOTS];
	bit [31:0] id_of[SLOTS];
	int        link_of[SLOTS];
	bit        used[SLOTS];
	int        head;
	int        count;
	bit [31:0] next_id;
	dlts_pkg::out_t pending[$];
	int        errors;
	int        checked;

	function new();
		for (int i = 0; i < SLOTS; i++) begin
			used[i] = 0;
			delay_of[i] = '0;
			link_of[i] = NIL;
		end
		head = NIL;
		count = 0;
		next_id = '0;
		errors = 0;
		checked = 0;
	endfunction

	// return the new id, or 0 when the add is refused
	function bit [31:0] insert(bit [7:0] tag, bit [31:0] dly, bit [31:0] per);
		int s, cur, prv;
		longint unsigned acc, prior;
		s = 0;
		if (tag == 0 || count >= SLOTS) return '0;
		while (s < SLOTS && used[s]) s++;
		if (s >= SLOTS) return '0;
		next_id = next_id + 32'd1;
		used[s] = 1;
		tag_of[s] = tag;
		period_of[s] = per;
		id_of[s] = next_id;
		count++;
		acc = 0;
		prv = NIL;
		cur = head;
		for (int k = 0; cur < SLOTS && k < SLOTS; k++) begin
			prior = acc;
			acc += delay_of[cur];
			if (acc > dly) begin
				delay_of[s] = 32'(dly - prior);
				delay_of[cur] = 32'(acc - dly);
				link_of[s] = cur;
				if (prv < SLOTS) link_of[prv] = s;
				else head = s;
				return next_id;
			end
			prv = cur;
			cur = link_of[cur];
		end
		delay_of[s] = 32'(dly - acc);
		link_of[s] = NIL;
		if (prv < SLOTS) link_of[prv] = s;
		else head = s;
		return next_id;
	endfunction

	function bit remove(bit [31:0] id);
		int cur, prv, nxt;
		cur = head;
		prv = NIL;
		if (id == 0) return 0;
		for (int k = 0; cur < SLOTS && k < SLOTS; k++) begin
			if (id_of[cur] == id) begin
				nxt = link_of[cur];
				if (nxt < SLOTS) delay_of[nxt] = delay_of[nxt] + delay_of[cur];
				if (prv < SLOTS) link_of[prv] = nxt;
				else head = nxt;
				used[cur] = 0;
				if (count > 0) count--;
				return 1;
			end
			prv = cur;
			cur = link_of[cur];
		end
		return 0;
	endfunction

	function void push(bit [1:0] st, bit [31:0] id, bit [7:0] tag, bit last);
		dlts_pkg::out_t r;
		r.status = st;
		r.result_id = id;
		r.result_tag = tag;
		r.is_last = last;
		pending.push_back(r);
	endfunction

	// note an accepted command and queue its expected beats
	function void note_command(dlts_pkg::in_t c);
		bit [31:0] id, p, prior_id;
		bit [7:0] t;
		int n;
		n = 0;
		case (c.command)
			dlts_pkg::CMD_TICK: begin
				if (head < SLOTS && delay_of[head] > 0) delay_of[head]--;
				push(dlts_pkg::ST_OK, '0, '0, 1);
			end
			dlts_pkg::CMD_ADD: begin
				// an add succeeded when the id counter moved; a wrapped id of
				// zero is still a success
				prior_id = next_id;
				id = insert(c.task_tag, c.start_delay, c.repeat_period);
				if (next_id != prior_id) push(dlts_pkg::ST_OK, id, '0, 1);
				else push(dlts_pkg::ST_FAIL, '0, '0, 1);
			end
			dlts_pkg::CMD_DELETE: begin
				if (remove(c.target_id)) push(dlts_pkg::ST_OK, c.target_id, '0, 1);
				else push(dlts_pkg::ST_FAIL, '0, '0, 1);
			end
			default: begin
				while (n < dlts_pkg::MAX_OUT && head < SLOTS && delay_of[head] == 0) begin
					id = id_of[head];
					t = tag_of[head];
					p = period_of[head];
					if (!remove(id)) break;
					if (p > 0) void'(insert(t, p, p));
					push(dlts_pkg::ST_OK, id, t, 0);
					n++;
				end
				if (n == 0) push(dlts_pkg::ST_NONE, '0, '0, 1);
				else pending[$].is_last = 1;
			end
		endcase
	endfunction

	function void check_result(dlts_pkg::out_t got);
		dlts_pkg::out_t want;
		if (pending.size() == 0) begin
			$error("result beat with nothing expected: %h", got);
			errors++;
			return;
		end
		want = pending.pop_front();
		checked++;
		if (got.status !== want.status) begin
			$error("status: expected %0d, got %0d", want.status, got.status);
			errors++;
		end
		if (got.result_id !== want.result_id) begin
			$error("result_id: expected %0d, got %0d", want.result_id, got.result_id);
			errors++;
		end
		if (got.result_tag !== want.result_tag) begin
			$error("result_tag: expected %0d, got %0d", want.result_tag, got.result_tag);
			errors++;
		end
		if (got.is_last !== want.is_last) begin
			$error("is_last: expected %0d, got %0d", want.is_last, got.is_last);
			errors++;
		end
	endfunction
endclass

module testbench;
	import dlts_pkg::*;

	localparam int STALL_LIMIT = 20000;

	logic clk = 0;
	logic arst_n = 0;
	logic start = 0;
	logic busy;
	in_t  request = '0;
	logic result_valid;
	out_t result;

	timer_queue_board board;
	int idle_cycles = 0;
	int issued = 0;
	int dispatched = 0;
	bit [31:0] recent_ids[$];

	delta_list_task_scheduler_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.request(request),
		.result_valid(result_valid),
		.result(result)
	);

	always #10 clk = ~clk;

	// check every result beat at the edge that takes it
	always @(posedge clk) begin
		if (arst_n && result_valid) begin
			board.check_result(result);
			if (result.result_tag != 0) dispatched++;
			if (result.status == ST_OK && result.result_id != 0) recent_ids.push_back(result.result_id);
			if (recent_ids.size() > 32) void'(recent_ids.pop_front());
		end
	end

	// watchdog: count cycles with no beat on either side
	always @(posedge clk) begin
		if (arst_n && ((start && !busy) || result_valid)) idle_cycles <= 0;
		else if (arst_n) idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("watchdog expired");
			$display("status: fail");
			$finish;
		end
	end

	// hold start until the block takes the beat; start stays high into the
	// next send unless a gap or a drain drops it
	task automatic send(in_t c);
		request <= c;
		start <= 1;
		@(posedge clk);
		while (busy) @(posedge clk);
		board.note_command(c);
		issued++;
		@(negedge clk);
	endtask

	// mostly short gaps, now and then a long one, often none at all
	task automatic gap();
		int n;
		n = 0;
		case ($urandom_range(0, 9))
			0, 1, 2, 3: n = 0;
			9: n = $urandom_range(10, 40);
			default: n = $urandom_range(1, 3);
		endcase
		if (n > 0) start <= 0;
		repeat (n) @(negedge clk);
	endtask

	task automatic drain();
		start <= 0;
		while (board.pending.size() != 0) @(negedge clk);
		repeat (60) @(negedge clk);
	endtask

	function automatic in_t mk(bit [1:0] cmd, bit [7:0] tag, bit [31:0] dly, bit [31:0] per,
			bit [31:0] id);
		in_t c;
		c.command = cmd;
		c.task_tag = tag;
		c.start_delay = dly;
		c.repeat_period = per;
		c.target_id = id;
		return c;
	endfunction

	function automatic bit [31:0] wide();
		case ($urandom_range(0, 3))
			0: return $urandom();
			1: return 32'hFFFF_FFFF - $urandom_range(0, 3);
			default: return $urandom_range(0, 6);
		endcase
	endfunction

	function automatic in_t pick();
		bit [31:0] id;
		int r;
		r = $urandom_range(0, 99);
		if (r < 30) return mk(CMD_TICK, 8'($urandom()), $urandom(), $urandom(), $urandom());
		if (r < 60)
			return mk(CMD_ADD, ($urandom_range(0, 19) == 0) ? 8'd0 : 8'($urandom_range(1, 255)),
				wide(), ($urandom_range(0, 2) == 0) ? 32'd0 : wide(), $urandom());
		if (r < 78) begin
			if (recent_ids.size() != 0 && $urandom_range(0, 3) != 0)
				id = recent_ids[$urandom_range(0, recent_ids.size() - 1)];
			else
				id = ($urandom_range(0, 1)) ? 32'd0 : $urandom();
			return mk(CMD_DELETE, 8'($urandom()), $urandom(), $urandom(), id);
		end
		return mk(CMD_DISPATCH, 8'($urandom()), $urandom(), $urandom(), $urandom());
	endfunction

	initial begin
		board = new();
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// directed: empty queue, rejects, extremes, a full queue and a big dispatch
		send(mk(CMD_TICK, 8'hFF, '1, '1, '1));
		send(mk(CMD_DISPATCH, 8'h00, '0, '0, '0));
		send(mk(CMD_DELETE, 8'h00, '0, '0, 32'd0));
		send(mk(CMD_DELETE, 8'h00, '0, '0, 32'hFFFF_FFFF));
		send(mk(CMD_ADD, 8'h00, 32'd5, 32'd0, '0));
		send(mk(CMD_ADD, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '1));
		send(mk(CMD_ADD, 8'h01, 32'd0, 32'd1, '0));
		send(mk(CMD_DISPATCH, 8'h00, '0, '0, '0));
		send(mk(CMD_DELETE, 8'h00, '0, '0, 32'd1));
		for (int i = 0; i < 15; i++)
			send(mk(CMD_ADD, 8'(i + 2), 32'(i % 3), (i % 2) ? 32'd2 : 32'd0, '0));
		send(mk(CMD_ADD, 8'hAA, 32'd1, 32'd0, '0));
		send(mk(CMD_TICK, 8'h00, '0, '0, '0));
		send(mk(CMD_TICK, 8'h00, '0, '0, '0));
		send(mk(CMD_DISPATCH, 8'h00, '0, '0, '0));
		send(mk(CMD_DISPATCH, 8'h00, '0, '0, '0));
		drain();

		// random commands; pause once midway until every result has come
		for (int i = 0; i < 370; i++) begin
			if (i == 185) drain();
			send(pick());
			gap();
		end
		drain();

		$display("covered %0d commands, %0d result beats, %0d tasks dispatched",
			issued, board.checked, dispatched);
		if (board.errors == 0 && board.pending.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end
endmodule

`default_nettype wire

// File: files.f
design/dlts_pkg.sv
design/dlts_ctrl.sv
design/dlts_datapath.sv
design/delta_list_task_scheduler_unit.sv
dv/testbench.sv
